>>> design/mpdct_pkg.sv
// Shared types and constants for the proportional-mouse cursor tracker.
// Used by the register file, the shared divider and the top level.
// No dependencies.
package mpdct_pkg;

  localparam int unsigned PotW    = 8;
  localparam int unsigned MagW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DIVISOR  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_JUMP     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_THRESH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HOME_X   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HOME_Y   = 3'd7;

  // Reset values of the registers and of the cursor.
  localparam logic [7:0] RST_DIVISOR = 8'd24;
  localparam logic [6:0] RST_JUMP    = 7'd50;
  localparam logic [6:0] RST_THRESH  = 7'd2;
  localparam logic [7:0] RST_WIDTH   = 8'd40;
  localparam logic [7:0] RST_HEIGHT  = 8'd25;
  localparam logic [7:0] RST_HOME_X  = 8'd20;
  localparam logic [7:0] RST_HOME_Y  = 8'd12;

  // Input item commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  typedef struct packed {
    logic       enable;
    logic [7:0] divisor;
    logic [6:0] jump_limit;
    logic [6:0] min_step_threshold;
    logic [7:0] scr_cols;
    logic [7:0] scr_rows;
    logic [7:0] home_x;
    logic [7:0] home_y;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] dividend;
    logic [PotW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MagW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/mouse_pot_delta_cursor_tracker_core.sv
// Top level of the proportional-mouse cursor tracker.
// Depends on mpdct_pkg, mpdct_cfg and mpdct_div.
//
// Each transfer on the input channel is one mouse sample or a start command.
// For a sample, each axis takes the 8-bit wrapped difference between the pot
// reading and the stored baseline, drops it as a glitch when its magnitude is
// above the jump limit, and divides it by the divisor with truncation toward
// zero; a zero quotient becomes one step when the magnitude is above the
// minimum step threshold. The Y step is inverted and the cursor is clamped to
// the screen. A start command loads the baseline and puts the cursor at home
// without clamping, whether or not tracking is enabled. Every input transfer
// produces exactly one output transfer carrying the cursor, a moved flag, the
// button state and a click on the press edge. A single restoring divider is
// shared by both axes and produces one quotient bit per cycle. For an enabled
// sample each axis is launched on the divider, gets its seven quotient bits
// and has its quotient captured, X before Y; then the move is applied and the
// result is loaded into the output register, after which the next input
// transfer can be taken. Start commands and disabled samples skip the divider
// and go straight to loading the output register. The block takes one item at
// a time, but a finished result sits in its own output register, so the next
// item is accepted while the previous result still waits to be taken.
// Configuration writes through the plain write port take effect on the next
// clock and are meant to be done while the block is idle.
module mouse_pot_delta_cursor_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [mpdct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mpdct_pkg::CfgDatW-1:0]  cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [mpdct_pkg::PotW-1:0]     pot_x_i,
  input  logic [mpdct_pkg::PotW-1:0]     pot_y_i,
  input  logic                           fire_line_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mpdct_pkg::PotW-1:0]     cursor_x_o,
  output logic [mpdct_pkg::PotW-1:0]     cursor_y_o,
  output logic                           moved_o,
  output logic                           button_down_o,
  output logic                           click_o
);
  import mpdct_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STX   = 3'd1;  // launch the divider on the X axis
  localparam logic [2:0] S_WX    = 3'd2;  // wait for the X quotient
  localparam logic [2:0] S_STY   = 3'd3;  // launch the divider on the Y axis
  localparam logic [2:0] S_WY    = 3'd4;  // wait for the Y quotient
  localparam logic [2:0] S_APPLY = 3'd5;  // move and clamp the cursor
  localparam logic [2:0] S_DONE  = 3'd6;  // hand the result to the output register

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]      state_q, state_d;
  logic [PotW-1:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic [PotW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic            btn_now_q, btn_now_d, btn_before_q, btn_before_d;
  logic            moved_q, moved_d;
  logic [PotW-1:0] pot_x_q, pot_x_d, pot_y_q, pot_y_d;
  logic            fire_q, fire_d;
  logic [MagW-1:0] qx_q, qx_d, qy_q, qy_d;

  logic            out_valid_q, out_valid_d;
  logic [PotW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic            out_moved_q, out_moved_d, out_btn_q, out_btn_d, out_click_q, out_click_d;

  logic            in_xfer;
  logic            out_load;
  logic [PotW-1:0] diff_x, diff_y, mag_x, mag_y;
  logic [PotW-1:0] divisor_eff;
  logic [MagW-1:0] step_x, step_y;
  logic [PotW-1:0] new_x, new_y;

  mpdct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mpdct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Magnitude of an 8-bit wrapped difference read as a signed value.
  function automatic logic [PotW-1:0] wrap_mag(input logic [PotW-1:0] diff);
    return diff[PotW-1] ? PotW'(8'd0 - diff) : diff;
  endfunction

  // Step size of one axis: zero for no change or a glitch, else the quotient,
  // raised to one when it is zero and the magnitude passes the threshold.
  function automatic logic [MagW-1:0] step_mag(input logic [PotW-1:0] mag,
                                               input logic [MagW-1:0] quo,
                                               input logic [6:0]      jump,
                                               input logic [6:0]      thresh);
    logic [MagW-1:0] res;
    res = '0;
    if (mag != '0 && mag <= {1'b0, jump}) begin
      if (quo != '0) begin
        res = quo;
      end else if (mag > {1'b0, thresh}) begin
        res = MagW'(1);
      end
    end
    return res;
  endfunction

  // Move a cursor coordinate and clamp it to zero and to the screen limit.
  // A zero step leaves the coordinate alone, even when it is off screen.
  function automatic logic [PotW-1:0] move_pos(input logic [PotW-1:0] pos,
                                               input logic [MagW-1:0] smag,
                                               input logic            down,
                                               input logic [PotW-1:0] size);
    logic [PotW-1:0]   lim;
    logic signed [9:0] n;
    logic [PotW-1:0]   res;
    lim = (size == '0) ? '0 : PotW'(size - 1'b1);
    if (down) begin
      n = $signed({2'b00, pos}) - $signed({3'b000, smag});
    end else begin
      n = $signed({2'b00, pos}) + $signed({3'b000, smag});
    end
    if (smag == '0) begin
      res = pos;
    end else if (n < 0) begin
      res = '0;
    end else if (n > $signed({2'b00, lim})) begin
      res = lim;
    end else begin
      res = n[PotW-1:0];
    end
    return res;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign diff_x      = PotW'(pot_x_q - base_x_q);
  assign diff_y      = PotW'(pot_y_q - base_y_q);
  assign mag_x       = wrap_mag(diff_x);
  assign mag_y       = wrap_mag(diff_y);
  assign divisor_eff = (cfg.divisor == '0) ? PotW'(1) : cfg.divisor;

  // Only magnitudes that pass the jump limit reach the quotient, and those
  // are at most 127, so the low seven bits are the whole dividend.
  always_comb begin
    div_req.start    = (state_q == S_STX) || (state_q == S_STY);
    div_req.dividend = (state_q == S_STY) ? mag_y[MagW-1:0] : mag_x[MagW-1:0];
    div_req.divisor  = divisor_eff;
  end

  assign step_x = step_mag(mag_x, qx_q, cfg.jump_limit, cfg.min_step_threshold);
  assign step_y = step_mag(mag_y, qy_q, cfg.jump_limit, cfg.min_step_threshold);
  // X moves down when its difference is negative; Y is inverted.
  assign new_x  = move_pos(pos_x_q, step_x, diff_x[PotW-1], cfg.scr_cols);
  assign new_y  = move_pos(pos_y_q, step_y, !diff_y[PotW-1], cfg.scr_rows);

  always_comb begin
    state_d      = state_q;
    base_x_d     = base_x_q;
    base_y_d     = base_y_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    btn_now_d    = btn_now_q;
    btn_before_d = btn_before_q;
    moved_d      = moved_q;
    pot_x_d      = pot_x_q;
    pot_y_d      = pot_y_q;
    fire_d       = fire_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pot_x_d = pot_x_i;
          pot_y_d = pot_y_i;
          fire_d  = fire_line_i;
          moved_d = 1'b0;
          if (command_i == CMD_START) begin
            base_x_d = pot_x_i;
            base_y_d = pot_y_i;
            pos_x_d  = cfg.home_x;
            pos_y_d  = cfg.home_y;
            state_d  = S_DONE;
          end else if (cfg.enable) begin
            state_d = S_STX;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_STX: state_d = S_WX;
      S_WX: begin
        if (div_rsp.done) begin
          qx_d    = div_rsp.quotient;
          state_d = S_STY;
        end
      end
      S_STY: state_d = S_WY;
      S_WY: begin
        if (div_rsp.done) begin
          qy_d    = div_rsp.quotient;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        pos_x_d      = new_x;
        pos_y_d      = new_y;
        moved_d      = (new_x != pos_x_q) || (new_y != pos_y_q);
        base_x_d     = pot_x_q;
        base_y_d     = pot_y_q;
        btn_before_d = btn_now_q;
        btn_now_d    = !fire_q;  // the fire line is active low
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: loaded from the state when the sequencer finishes and
  // the register is free or being emptied in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_moved_d = out_moved_q;
    out_btn_d   = out_btn_q;
    out_click_d = out_click_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_x_d     = pos_x_q;
      out_y_d     = pos_y_q;
      out_moved_d = moved_q;
      out_btn_d   = btn_now_q;
      out_click_d = btn_now_q && !btn_before_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_x_q     <= '0;
      base_y_q     <= '0;
      pos_x_q      <= RST_HOME_X;
      pos_y_q      <= RST_HOME_Y;
      btn_now_q    <= 1'b0;
      btn_before_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_x_q     <= base_x_d;
      base_y_q     <= base_y_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      btn_now_q    <= btn_now_d;
      btn_before_q <= btn_before_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    moved_q     <= moved_d;
    pot_x_q     <= pot_x_d;
    pot_y_q     <= pot_y_d;
    fire_q      <= fire_d;
    qx_q        <= qx_d;
    qy_q        <= qy_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_moved_q <= out_moved_d;
    out_btn_q   <= out_btn_d;
    out_click_q <= out_click_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = out_x_q;
  assign cursor_y_o    = out_y_q;
  assign moved_o       = out_moved_q;
  assign button_down_o = out_btn_q;
  assign click_o       = out_click_q;

  // The divider is never launched while it is still working on an axis.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider launched while busy");

  // A quotient only arrives while the sequencer waits for one.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_WX || state_q == S_WY))
    else $error("divider result arrived outside a wait state");

  // A start command puts the cursor at home on the next cycle.
  a_start_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && command_i == CMD_START) |=>
      (pos_x_q == $past(cfg.home_x) && pos_y_q == $past(cfg.home_y)))
    else $error("start command did not home the cursor");

endmodule

>>> design/mpdct_cfg.sv
// Configuration register file of the cursor tracker.
// Depends on mpdct_pkg for the register indexes, reset values and cfg_t.
module mpdct_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpdct_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mpdct_pkg::CfgDatW-1:0]     cfg_wdata_i,
  output mpdct_pkg::cfg_t                   cfg_o
);
  import mpdct_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:  cfg_d.enable             = cfg_wdata_i[0];
        REG_DIVISOR: cfg_d.divisor            = cfg_wdata_i;
        REG_JUMP:    cfg_d.jump_limit         = cfg_wdata_i[6:0];
        REG_THRESH:  cfg_d.min_step_threshold = cfg_wdata_i[6:0];
        REG_WIDTH:   cfg_d.scr_cols           = cfg_wdata_i;
        REG_HEIGHT:  cfg_d.scr_rows           = cfg_wdata_i;
        REG_HOME_X:  cfg_d.home_x             = cfg_wdata_i;
        REG_HOME_Y:  cfg_d.home_y             = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable             <= 1'b0;
      cfg_q.divisor            <= RST_DIVISOR;
      cfg_q.jump_limit         <= RST_JUMP;
      cfg_q.min_step_threshold <= RST_THRESH;
      cfg_q.scr_cols           <= RST_WIDTH;
      cfg_q.scr_rows           <= RST_HEIGHT;
      cfg_q.home_x             <= RST_HOME_X;
      cfg_q.home_y             <= RST_HOME_Y;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/mpdct_div.sv
// Shared restoring divider: a 7-bit magnitude by an 8-bit divisor, one
// quotient bit per cycle. Depends on mpdct_pkg for the request and response types.
module mpdct_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpdct_pkg::div_req_t  req_i,
  output mpdct_pkg::div_rsp_t  rsp_o
);
  import mpdct_pkg::*;

  localparam int unsigned CntW = $clog2(MagW);
  localparam logic [CntW-1:0] LastStep = CntW'(MagW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PotW-1:0] rem_q, rem_d;
  logic [MagW-1:0] quo_q, quo_d;
  logic [PotW-1:0] dvs_q, dvs_d;
  logic [PotW:0]   shifted;
  logic            fits;

  assign shifted = {rem_q, quo_q[MagW-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits in PotW bits.
      if (fits) begin
        rem_d = PotW'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = shifted[PotW-1:0];
      end
      quo_d = {quo_q[MagW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
